>>> design/prf_pkg.sv
// shared types and constants for the paeth residual filter
// no dependencies; imported by the interfaces and all modules
`default_nettype none

package prf_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int WIDTH_W   = 13;
  localparam int HEIGHT_W  = 16;
  localparam int PLANES_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef logic [15:0]          sample_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [WIDTH_W-1:0]   width_t;
  typedef logic [HEIGHT_W-1:0]  height_t;
  typedef logic [PLANES_W-1:0]  planes_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_PLANE_COUNT  = 2'd2;

  localparam width_t  WIDTH_RST  = width_t'(MAX_WIDTH);
  localparam height_t HEIGHT_RST = height_t'(1);
  localparam planes_t PLANES_RST = planes_t'(1);

  // position of an item within the image, carried down the pipeline
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic plane_end;
    logic image_end;
  } pos_t;

endpackage

`default_nettype wire

>>> design/prf_if.sv
// valid/ready channel interfaces for sample items and residual items
// depends on prf_pkg
`default_nettype none

interface prf_in_if;
  import prf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface prf_out_if;
  import prf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t residual;
  logic    plane_end;
  logic    image_end;
  modport source (output valid, output residual, output plane_end, output image_end,
                  input ready);
  modport sink   (input valid, input residual, input plane_end, input image_end,
                  output ready);
endinterface

`default_nettype wire

>>> design/paeth_residual_filter_u16_unit.sv
// paeth residual filter for planar 16-bit images, top level
// depends on prf_pkg, prf_if and prf_paeth
// path: an accepted item passes the stage-1 registers, then the output register, to out_chan
// throughput: one item per cycle unless out_chan.ready stalls the output; each item does one
//   read-then-write of the row store at its column, so the single memory port sets the rate
// reset: counters, left/upper-left samples and sizes return to defaults;
//   the row store is not cleared and needs no clearing pass
`default_nettype none

module paeth_residual_filter_u16_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  prf_in_if.sink              in_chan,
  prf_out_if.source           out_chan,
  input  wire                 cfg_we,
  input  prf_pkg::cfg_idx_t   cfg_index,
  input  prf_pkg::cfg_dat_t   cfg_wdata
);
  import prf_pkg::*;

  // configuration
  width_t  width_r;
  height_t height_r;
  planes_t planes_r;

  // stream position
  col_t    col_r;
  height_t row_r;
  planes_t plane_r;

  // row store, read-first when read and written in the same cycle
  sample_t row_mem [MAX_WIDTH];
  sample_t up_q;

  // stage 1
  logic    v1_r;
  sample_t s1_r;
  pos_t    pos1_r;
  sample_t left_r, upleft_r;

  // output register
  logic    out_v_r;
  sample_t res_r;
  logic    pend_r, iend_r;

  logic    in_acc, adv1;
  width_t  w_eff;
  height_t h_eff;
  planes_t pc_eff;
  logic    row_wrap, plane_wrap, image_wrap;
  col_t    col_nxt;
  height_t row_nxt;
  planes_t plane_nxt;
  pos_t    pos0;
  sample_t paeth_pred, pred;

  assign adv1           = !out_v_r || out_chan.ready;
  assign in_chan.ready  = !v1_r || adv1;
  assign in_acc         = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      planes_r <= PLANES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        CFG_PLANE_COUNT:  planes_r <= cfg_wdata[PLANES_W-1:0];
        default: ;
      endcase
    end
  end

  // zero sizes count as one, width clamps to the store depth
  always_comb begin
    if (width_r == '0) begin
      w_eff = width_t'(1);
    end else if (width_r > width_t'(MAX_WIDTH)) begin
      w_eff = width_t'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff  = (height_r == '0) ? height_t'(1) : height_r;
    pc_eff = (planes_r == '0) ? planes_t'(1) : planes_r;
  end

  assign row_wrap   = ({1'b0, col_r} + width_t'(1)) >= w_eff;
  assign plane_wrap = row_wrap && (({1'b0, row_r} + 17'd1) >= {1'b0, h_eff});
  assign image_wrap = plane_wrap && (({1'b0, plane_r} + 9'd1) >= {1'b0, pc_eff});

  always_comb begin
    col_nxt   = row_wrap ? '0 : col_r + col_t'(1);
    row_nxt   = row_r;
    plane_nxt = plane_r;
    if (row_wrap) begin
      row_nxt = plane_wrap ? '0 : row_r + height_t'(1);
    end
    if (plane_wrap) begin
      plane_nxt = image_wrap ? '0 : plane_r + planes_t'(1);
    end
  end

  assign pos0.first_row = (row_r == '0);
  assign pos0.first_col = (col_r == '0);
  assign pos0.plane_end = plane_wrap;
  assign pos0.image_end = image_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else if (in_acc) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

  // up sample is registered, ready the cycle after the accept; the entry takes the new sample at once
  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_q           <= row_mem[col_r];
      row_mem[col_r] <= in_chan.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_chan.ready) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r   <= in_chan.sample;
      pos1_r <= pos0;
    end
  end

  prf_paeth u_paeth (
    .a    (left_r),
    .b    (up_q),
    .c    (upleft_r),
    .pred (paeth_pred)
  );

  always_comb begin
    if (pos1_r.first_row) begin
      pred = pos1_r.first_col ? '0 : left_r;
    end else if (pos1_r.first_col) begin
      pred = up_q;
    end else begin
      pred = paeth_pred;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      upleft_r <= '0;
    end else if (v1_r && adv1) begin
      left_r   <= s1_r;
      upleft_r <= up_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv1) begin
      out_v_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && adv1) begin
      res_r  <= s1_r - pred;
      pend_r <= pos1_r.plane_end;
      iend_r <= pos1_r.image_end;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.residual  = res_r;
  assign out_chan.plane_end = pend_r;
  assign out_chan.image_end = iend_r;

endmodule

`default_nettype wire

>>> design/prf_paeth.sv
// paeth prediction from left, up and upper-left samples
// depends on prf_pkg
`default_nettype none

module prf_paeth (
  input  prf_pkg::sample_t a,
  input  prf_pkg::sample_t b,
  input  prf_pkg::sample_t c,
  output prf_pkg::sample_t pred
);
  import prf_pkg::*;

  logic signed [17:0] da_s, db_s, dc_s;
  logic        [16:0] da, db, dc;

  // p - a = b - c, p - b = a - c, p - c = a + b - 2c
  assign da_s = $signed({2'b00, b}) - $signed({2'b00, c});
  assign db_s = $signed({2'b00, a}) - $signed({2'b00, c});
  assign dc_s = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});

  assign da = da_s[17] ? 17'(-da_s) : da_s[16:0];
  assign db = db_s[17] ? 17'(-db_s) : db_s[16:0];
  assign dc = dc_s[17] ? 17'(-dc_s) : dc_s[16:0];

  always_comb begin
    if (da <= db && da <= dc) begin
      pred = a;
    end else if (db <= dc) begin
      pred = b;
    end else begin
      pred = c;
    end
  end

endmodule

`default_nettype wire
